### rtl/core/tmcb_pkg.sv
// ----------------------------------------------------------------------------
// tmcb_pkg
// Shared types and constants of the triggered multichannel capture buffer.
// ----------------------------------------------------------------------------
package tmcb_pkg;

  localparam int MAX_CH     = 8;
  localparam int SAMPLE_W   = 8;
  localparam int CH_IDX_W   = 3;
  localparam int REC_IDX_W  = 16;
  localparam int LIMIT_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = MAX_CH * SAMPLE_W;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_DRAIN   = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASK  = 2'd0,
    CFG_MODE  = 2'd1,
    CFG_LEVEL = 2'd2,
    CFG_LIMIT = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                 nodata;
    logic                 overrun;
    logic [REC_IDX_W-1:0] record_index;
    logic [MAX_CH-1:0]    mask;
  } drain_info_t;

endpackage

### rtl/core/tmcb_lane.sv
// ----------------------------------------------------------------------------
// tmcb_lane
// One channel lane: gates the sample by its enable and compares it against
// the trigger level.
// ----------------------------------------------------------------------------
module tmcb_lane (
  input  logic [tmcb_pkg::SAMPLE_W-1:0] sample,
  input  logic                          enable,
  input  logic [tmcb_pkg::SAMPLE_W-1:0] level,
  output logic [tmcb_pkg::SAMPLE_W-1:0] lane_byte,
  output logic                          hit
);
  import tmcb_pkg::*;

  assign lane_byte = enable ? sample : '0;
  assign hit       = enable && (sample >= level);

endmodule

### rtl/core/tmcb_ring.sv
// ----------------------------------------------------------------------------
// tmcb_ring
// Merges the lane results into one record, runs the capture policy and holds
// the record ring with its pointers, counters and flags.
// ----------------------------------------------------------------------------
module tmcb_ring #(
  parameter int RING_DEPTH = 256,
  parameter int CHANNELS   = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  op_valid,
  input  tmcb_pkg::op_t                         op,
  input  logic [CHANNELS*tmcb_pkg::SAMPLE_W-1:0] lane_rec,
  input  logic [CHANNELS-1:0]                   lane_hit,
  input  logic                                  capture_mode,
  input  logic [tmcb_pkg::LIMIT_W-1:0]          sample_limit,
  input  logic [tmcb_pkg::MAX_CH-1:0]           active_mask,
  output logic                                  drain_start,
  output tmcb_pkg::drain_info_t                 drain_info,
  output logic [CHANNELS*tmcb_pkg::SAMPLE_W-1:0] rd_data
);
  import tmcb_pkg::*;

  localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FW = $clog2(RING_DEPTH + 1);
  localparam int RW = CHANNELS * SAMPLE_W;
  localparam logic [FW-1:0] FILL_FULL = FW'(RING_DEPTH);
  localparam logic [PW-1:0] SLOT_LAST = PW'(RING_DEPTH - 1);

  logic [RW-1:0]        mem [RING_DEPTH];
  logic [PW-1:0]        write_pointer;
  logic [PW-1:0]        read_pointer;
  logic [FW-1:0]        fill_count;
  logic                 triggered_flag;
  logic [LIMIT_W-1:0]   stored_total;
  logic [REC_IDX_W-1:0] drained_total;
  logic                 overrun_flag;

  logic is_tick, is_drain, is_restart;
  logic hit_any, full, nodata;
  logic do_commit, do_write, do_pop, set_overrun, set_trig;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    return (p == SLOT_LAST) ? '0 : p + PW'(1);
  endfunction

  assign is_tick    = op_valid && (op == OP_TICK);
  assign is_drain   = op_valid && (op == OP_DRAIN);
  assign is_restart = op_valid && (op == OP_RESTART);
  assign hit_any    = |lane_hit;
  assign full       = (fill_count == FILL_FULL);
  assign nodata     = (fill_count == '0) || (active_mask == '0);
  assign do_pop     = is_drain && !nodata;

  always_comb begin
    do_commit   = 1'b0;
    do_write    = 1'b0;
    set_overrun = 1'b0;
    set_trig    = 1'b0;
    if (is_tick) begin
      if (!capture_mode) begin
        if (stored_total < sample_limit) begin
          if (full) begin
            set_overrun = 1'b1;
          end else begin
            do_commit = 1'b1;
          end
        end
      end else if (!full) begin
        set_trig  = hit_any;
        do_commit = hit_any || triggered_flag;
        do_write  = 1'b1;
      end
    end
    do_write = do_write || do_commit;
  end

  always_ff @(posedge clk) begin
    if (rst || is_restart) begin
      write_pointer  <= '0;
      read_pointer   <= '0;
      fill_count     <= '0;
      triggered_flag <= 1'b0;
      stored_total   <= '0;
      drained_total  <= '0;
      overrun_flag   <= 1'b0;
    end else begin
      if (do_commit) begin
        write_pointer <= next_slot(write_pointer);
        stored_total  <= stored_total + LIMIT_W'(1);
      end
      if (do_pop) begin
        read_pointer  <= next_slot(read_pointer);
        drained_total <= drained_total + REC_IDX_W'(1);
      end
      if (do_commit && !do_pop) begin
        fill_count <= fill_count + FW'(1);
      end else if (do_pop && !do_commit) begin
        fill_count <= fill_count - FW'(1);
      end
      if (set_trig) begin
        triggered_flag <= 1'b1;
      end
      if (set_overrun) begin
        overrun_flag <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[write_pointer] <= lane_rec;
    end
    if (do_pop) begin
      rd_data <= mem[read_pointer];
    end
  end

  assign drain_start             = is_drain;
  assign drain_info.nodata       = nodata;
  assign drain_info.overrun      = overrun_flag;
  assign drain_info.record_index = drained_total;
  assign drain_info.mask         = active_mask;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_FULL)
    else $error("fill count above ring depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (fill_count == '0) |-> (write_pointer == read_pointer))
    else $error("empty ring with unequal pointers");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    is_restart |=> (fill_count == '0) && !triggered_flag && !overrun_flag)
    else $error("restart did not clear capture state");

endmodule

### rtl/core/tmcb_emit.sv
// ----------------------------------------------------------------------------
// tmcb_emit
// Walks the enabled channels of a drained record in ascending order, one
// result per transfer, or gives a single no-data result.
// ----------------------------------------------------------------------------
module tmcb_emit #(
  parameter int CHANNELS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  tmcb_pkg::drain_info_t                 info,
  input  logic [CHANNELS*tmcb_pkg::SAMPLE_W-1:0] rec,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic                                  has_data,
  output logic [tmcb_pkg::CH_IDX_W-1:0]         channel_index,
  output logic [tmcb_pkg::SAMPLE_W-1:0]         sample_value,
  output logic [tmcb_pkg::REC_IDX_W-1:0]        record_index,
  output logic                                  overrun,
  output logic                                  last_of_record,
  output logic                                  free
);
  import tmcb_pkg::*;

  logic [MAX_CH-1:0]    rem;
  logic                 nodata_q;
  logic [REC_IDX_W-1:0] idx_q;
  logic                 ovr_q;
  logic [MAX_CH-1:0]    low_bit;
  logic [IN_DATA_W-1:0] rec_wide;
  logic                 xfer;

  assign out_valid = nodata_q || (rem != '0);
  assign xfer      = out_valid && out_ready;
  assign low_bit   = rem & (~rem + MAX_CH'(1));
  assign rec_wide  = IN_DATA_W'(rec);

  always_comb begin
    channel_index = '0;
    for (int i = MAX_CH - 1; i >= 0; i--) begin
      if (rem[i]) begin
        channel_index = CH_IDX_W'(i);
      end
    end
  end

  assign has_data       = !nodata_q;
  assign sample_value   = nodata_q ? '0 : rec_wide[channel_index*SAMPLE_W +: SAMPLE_W];
  assign record_index   = idx_q;
  assign overrun        = ovr_q;
  assign last_of_record = nodata_q || ((rem & (rem - MAX_CH'(1))) == '0);
  assign free           = !out_valid || (xfer && last_of_record);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem      <= '0;
      nodata_q <= 1'b0;
    end else if (start) begin
      rem      <= info.nodata ? '0 : info.mask;
      nodata_q <= info.nodata;
    end else if (xfer) begin
      rem      <= rem & ~low_bit;
      nodata_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx_q <= info.record_index;
      ovr_q <= info.overrun;
    end
  end

  a_start_free: assert property (@(posedge clk) disable iff (rst)
    start |-> free)
    else $error("drain started while results pending");

  a_nodata_alone: assert property (@(posedge clk) disable iff (rst)
    nodata_q |-> (rem == '0))
    else $error("no-data result with channels pending");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (rem >> CHANNELS) == '0)
    else $error("pending channel beyond channel count");

endmodule

### rtl/core/triggered_multichannel_capture_buffer_top.sv
// ----------------------------------------------------------------------------
// triggered_multichannel_capture_buffer_top
// Eight-channel capture ring with continuous and triggered modes and a
// per-channel drain stream.
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    tdata samples, tuser op
// m_*       out  m_tvalid/m_tready    tdata result, tuser has_data, tlast
// cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Ticks and restarts are taken every cycle; the ring has one write and one
// read port, both used at most once per cycle.
// A drain reads the ring into a register, then gives one result per output
// transfer (1 to CHANNELS); the next drain waits until the last one is taken.
// Reset is synchronous and needs no clearing pass; cfg_ready is always high.
// ----------------------------------------------------------------------------
module triggered_multichannel_capture_buffer_top #(
  parameter int RING_DEPTH = 256,
  parameter int CHANNELS   = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [tmcb_pkg::IN_DATA_W-1:0]    s_tdata,   // sample_ch0 .. sample_ch7
  input  logic [1:0]                        s_tuser,   // func
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [tmcb_pkg::OUT_DATA_W-1:0]   m_tdata,   // channel_index, sample_value,
                                                       // record_index, overrun, zero pad
  output logic                              m_tuser,   // has_data
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tmcb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tmcb_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tmcb_pkg::*;

  localparam int RW = CHANNELS * SAMPLE_W;

  logic [MAX_CH-1:0]    channel_mask;
  logic                 capture_mode;
  logic [SAMPLE_W-1:0]  trigger_level;
  logic [LIMIT_W-1:0]   sample_limit;
  logic [MAX_CH-1:0]    active_mask;

  op_t                  op;
  logic                 op_valid;
  logic [RW-1:0]        lane_rec;
  logic [CHANNELS-1:0]  lane_hit;
  logic                 drain_start;
  drain_info_t          drain_info;
  logic [RW-1:0]        rd_data;
  logic                 emit_free;

  logic                 has_data;
  logic [CH_IDX_W-1:0]  channel_index;
  logic [SAMPLE_W-1:0]  sample_value;
  logic [REC_IDX_W-1:0] record_index;
  logic                 overrun;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_mask  <= '0;
      capture_mode  <= 1'b0;
      trigger_level <= '0;
      sample_limit  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MASK:  channel_mask  <= cfg_data[MAX_CH-1:0];
        CFG_MODE:  capture_mode  <= cfg_data[0];
        CFG_LEVEL: trigger_level <= cfg_data[SAMPLE_W-1:0];
        CFG_LIMIT: sample_limit  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign active_mask = channel_mask & MAX_CH'((1 << CHANNELS) - 1);

  assign op       = op_t'(s_tuser);
  assign s_tready = (op != OP_DRAIN) || emit_free;
  assign op_valid = s_tvalid && s_tready;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    tmcb_lane u_lane (
      .sample    (s_tdata[g*SAMPLE_W +: SAMPLE_W]),
      .enable    (active_mask[g]),
      .level     (trigger_level),
      .lane_byte (lane_rec[g*SAMPLE_W +: SAMPLE_W]),
      .hit       (lane_hit[g])
    );
  end

  tmcb_ring #(
    .RING_DEPTH (RING_DEPTH),
    .CHANNELS   (CHANNELS)
  ) u_ring (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (op_valid),
    .op           (op),
    .lane_rec     (lane_rec),
    .lane_hit     (lane_hit),
    .capture_mode (capture_mode),
    .sample_limit (sample_limit),
    .active_mask  (active_mask),
    .drain_start  (drain_start),
    .drain_info   (drain_info),
    .rd_data      (rd_data)
  );

  tmcb_emit #(
    .CHANNELS (CHANNELS)
  ) u_emit (
    .clk            (clk),
    .rst            (rst),
    .start          (drain_start),
    .info           (drain_info),
    .rec            (rd_data),
    .out_ready      (m_tready),
    .out_valid      (m_tvalid),
    .has_data       (has_data),
    .channel_index  (channel_index),
    .sample_value   (sample_value),
    .record_index   (record_index),
    .overrun        (overrun),
    .last_of_record (m_tlast),
    .free           (emit_free)
  );

  assign m_tuser = has_data;
  assign m_tdata = {4'b0000, overrun, record_index, sample_value, channel_index};

endmodule
